@@ sv/header_length_checksum_deframer_defines.svh @@
// Assertion macros used by the deframer's port-level checker.
// Depends on a clk and an rst_n signal being visible where a macro is used.
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define HLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define HLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hlcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the frame deframer.
// No dependencies; used by the core, the top level and the checker.
package hlcd_pkg;

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [15:0] MIN_LENGTH = 16'd5;
  localparam logic [15:0] MAX_LENGTH = 16'd65532;
  localparam logic [15:0] CMD_LAST   = 16'd4;

  // Frame parser phase codes.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN_LO  = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_CMD     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  // Result kinds.
  localparam logic [2:0] K_PAYLOAD   = 3'd0;
  localparam logic [2:0] K_OK        = 3'd1;
  localparam logic [2:0] K_BAD_START = 3'd2;
  localparam logic [2:0] K_BAD_LEN   = 3'd3;
  localparam logic [2:0] K_BAD_SUM   = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] command_word;
    logic [15:0] payload_length;
    logic        frame_end;
  } result_t;

endpackage

@@ sv/hlcd_core.sv @@
`timescale 1ns / 1ps
// Frame parser state and its next-state and result logic.
// Depends on hlcd_pkg for phase codes, result kinds and the result struct.
module hlcd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output hlcd_pkg::result_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] bpos_r, bpos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] cmd_r, cmd_nxt;

  logic [15:0] plen;
  logic [15:0] len_full;
  logic [15:0] bpos_inc;
  logic [7:0]  sum_add;

  assign plen     = len_r - hlcd_pkg::MIN_LENGTH;
  assign len_full = {rx_byte, len_r[7:0]};
  assign bpos_inc = bpos_r + 16'd1;
  assign sum_add  = sum_r + rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    bpos_nxt  = bpos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    res       = '0;
    unique case (phase_r)
      hlcd_pkg::PH_LEN_LO: begin
        len_nxt   = {8'd0, rx_byte};
        sum_nxt   = sum_add;
        phase_nxt = hlcd_pkg::PH_LEN_HI;
      end
      hlcd_pkg::PH_LEN_HI: begin
        len_nxt = len_full;
        sum_nxt = sum_add;
        if (len_full < hlcd_pkg::MIN_LENGTH || len_full > hlcd_pkg::MAX_LENGTH) begin
          phase_nxt     = hlcd_pkg::PH_HUNT;
          res.valid     = 1'b1;
          res.kind      = hlcd_pkg::K_BAD_LEN;
          res.frame_end = 1'b1;
        end else begin
          bpos_nxt  = '0;
          cmd_nxt   = '0;
          phase_nxt = hlcd_pkg::PH_CMD;
        end
      end
      hlcd_pkg::PH_CMD: begin
        cmd_nxt  = {cmd_r[23:0], rx_byte};
        sum_nxt  = sum_add;
        bpos_nxt = bpos_inc;
        if (bpos_inc >= hlcd_pkg::CMD_LAST) begin
          bpos_nxt  = '0;
          phase_nxt = (plen == 16'd0) ? hlcd_pkg::PH_CHECK : hlcd_pkg::PH_PAYLOAD;
        end
      end
      hlcd_pkg::PH_PAYLOAD: begin
        sum_nxt  = sum_add;
        bpos_nxt = bpos_inc;
        if (bpos_inc >= plen) begin
          phase_nxt = hlcd_pkg::PH_CHECK;
        end
        res.valid        = 1'b1;
        res.kind         = hlcd_pkg::K_PAYLOAD;
        res.payload_byte = rx_byte;
      end
      hlcd_pkg::PH_CHECK: begin
        phase_nxt          = hlcd_pkg::PH_HUNT;
        res.valid          = 1'b1;
        res.kind           = (rx_byte == sum_r) ? hlcd_pkg::K_OK : hlcd_pkg::K_BAD_SUM;
        res.command_word   = cmd_r;
        res.payload_length = plen;
        res.frame_end      = 1'b1;
      end
      default: begin
        // Hunting, and the unused codes behave the same way.
        if (rx_byte == hlcd_pkg::START_BYTE) begin
          sum_nxt   = rx_byte;
          len_nxt   = '0;
          bpos_nxt  = '0;
          cmd_nxt   = '0;
          phase_nxt = hlcd_pkg::PH_LEN_LO;
        end else begin
          phase_nxt     = hlcd_pkg::PH_HUNT;
          res.valid     = 1'b1;
          res.kind      = hlcd_pkg::K_BAD_START;
          res.frame_end = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hlcd_pkg::PH_HUNT;
      bpos_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      cmd_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

@@ sv/header_length_checksum_deframer.sv @@
`timescale 1ns / 1ps
// Length-prefixed frame deframer with an 8-bit additive checksum.
// A byte accepted into the input register passes through the combinational parser step
// into the result register, where its result waits to be taken. Throughput: one byte per
// cycle unless a result meets a stalled result register. Synchronous active-low reset
// empties both registers and returns the parser to hunting for the start byte.
module header_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_command_word,
  output logic [15:0] out_payload_length,
  output logic        out_frame_end
);

  // Input register: holds one accepted byte until the parser consumes it.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Result register: holds one finished item until the downstream side takes it.
  logic        out_vld_r;
  logic [2:0]  kind_r;
  logic [7:0]  pbyte_r;
  logic [31:0] cmd_word_r;
  logic [15:0] plen_r;
  logic        fend_r;

  hlcd_pkg::result_t res;
  logic out_free;
  logic step;

  // The result register can take a new item when it is empty or being emptied.
  assign out_free = !out_vld_r || !out_stall;

  // The parser advances on a held byte unless that byte yields a result and the
  // result register has no room. Bytes that produce nothing never wait.
  assign step = in_vld_r && (!res.valid || out_free);

  // The input register refills in the same cycle that it drains.
  assign in_stall = in_vld_r && !step;

  hlcd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.valid) begin
      kind_r     <= res.kind;
      pbyte_r    <= res.payload_byte;
      cmd_word_r <= res.command_word;
      plen_r     <= res.payload_length;
      fend_r     <= res.frame_end;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = kind_r;
  assign out_payload_byte   = pbyte_r;
  assign out_command_word   = cmd_word_r;
  assign out_payload_length = plen_r;
  assign out_frame_end      = fend_r;

endmodule

@@ sv/hlcd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the deframer, attached to the top level by bind.
// Depends on hlcd_pkg and the assertion macros header.
`include "header_length_checksum_deframer_defines.svh"

module hlcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_payload_byte,
  input logic [31:0] out_command_word,
  input logic [15:0] out_payload_length,
  input logic        out_frame_end
);

  logic        in_seen;
  logic        end_kind;
  logic        end_seen;
  logic        framing_err;
  logic        err_clean;
  logic        out_hold;
  logic [59:0] out_word;

  assign in_seen     = in_valid && !in_stall;
  assign end_kind    = (out_kind != hlcd_pkg::K_PAYLOAD);
  assign end_seen    = out_valid && out_frame_end;
  assign framing_err = out_valid && ((out_kind == hlcd_pkg::K_BAD_START) ||
                                     (out_kind == hlcd_pkg::K_BAD_LEN));
  assign err_clean   = (out_command_word == 32'd0) && (out_payload_length == 16'd0);
  assign out_hold    = out_valid && out_stall;
  assign out_word    = {out_kind, out_payload_byte, out_command_word, out_payload_length,
                        out_frame_end};

  `HLCD_ASSERT_NOW(a_fend_kind, out_valid, out_frame_end == end_kind, "frame_end vs kind")
  `HLCD_ASSERT_NOW(a_end_no_byte, end_seen, out_payload_byte == 8'd0, "byte on a frame end")
  `HLCD_ASSERT_NOW(a_err_clean, framing_err, err_clean, "fields set on a framing error")
  `HLCD_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_word), "stalled item moved")
  `HLCD_ASSERT_NEXT(a_first_result, $rose(rst_n) && !in_seen, !out_valid, "early result")

endmodule

bind header_length_checksum_deframer hlcd_checker u_hlcd_checker (.*);
